### hw/rtl/zbuffer_span_fill_unit_defines.svh
// assertion macros for the span fill unit
`ifndef ZBUFFER_SPAN_FILL_UNIT_DEFINES_SVH
`define ZBUFFER_SPAN_FILL_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ZBSF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zbsf check failed");
`define ZBSF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zbsf check failed");
`else
`define ZBSF_ASSERT_IMP(lbl, ante, cons)
`define ZBSF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/zbsf_pkg.sv
`default_nettype none
package zbsf_pkg;

  localparam int DIM_W   = 13;
  localparam int CFG_W   = 11;
  localparam int DEPTH_W = 24;
  localparam int CH_W    = 12;
  localparam int COLOR_W = 36;
  localparam int PIX_W   = 60;
  localparam int X_W     = 10;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_SPAN  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FRAME_LEFT    = 3'd2;
  localparam logic [2:0] REG_FRAME_RIGHT   = 3'd3;
  localparam logic [2:0] REG_FRAME_BOTTOM  = 3'd4;
  localparam logic [2:0] REG_FRAME_TOP     = 3'd5;
  localparam logic [2:0] REG_BACKGROUND    = 3'd6;
  localparam logic [2:0] REG_FAR_DEPTH     = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_DIV,
    S_DIVW,
    S_WALK,
    S_DRAIN,
    S_READ,
    S_READW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [X_W-1:0]     row;
    logic [X_W-1:0]     left_x;
    logic [X_W-1:0]     right_x;
    logic [DEPTH_W-1:0] left_depth;
    logic [DEPTH_W-1:0] right_depth;
    logic [CH_W-1:0]    left_red;
    logic [CH_W-1:0]    left_green;
    logic [CH_W-1:0]    left_blue;
    logic [CH_W-1:0]    right_red;
    logic [CH_W-1:0]    right_green;
    logic [CH_W-1:0]    right_blue;
  } in_item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] pixel_depth;
    logic [CH_W-1:0]    pixel_red;
    logic [CH_W-1:0]    pixel_green;
    logic [CH_W-1:0]    pixel_blue;
    logic [CFG_W-1:0]   pixels_written;
    logic               range_error;
  } out_item_t;

endpackage
`default_nettype wire

### hw/rtl/zbsf_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module zbsf_div #(
  parameter int NUM_W = 40
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [NUM_W-1:0]              num,
  input  wire logic [zbsf_pkg::X_W-1:0]      den,
  output logic                               done,
  output logic [NUM_W-1:0]                   quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]          q_r;
  logic [zbsf_pkg::X_W-1:0]  rem_r;
  logic [zbsf_pkg::X_W-1:0]  den_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [zbsf_pkg::X_W:0]    trial;
  logic                      fits;

  assign trial = {rem_r, q_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? zbsf_pkg::X_W'(trial - {1'b0, den_r}) : trial[zbsf_pkg::X_W-1:0];
      q_r   <= {q_r[NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

### hw/rtl/zbsf_mem.sv
`default_nettype none
// frame store: depth in the upper bits, color below, one write and one read port
module zbsf_mem #(
  parameter int DEPTH  = 1048576,
  parameter int ADDR_W = 20
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [ADDR_W-1:0]           waddr,
  input  wire logic [zbsf_pkg::PIX_W-1:0]  wdata,
  input  wire logic                        re,
  input  wire logic [ADDR_W-1:0]           raddr,
  output logic      [zbsf_pkg::PIX_W-1:0]  rdata
);

  logic [zbsf_pkg::PIX_W-1:0] mem [DEPTH];
  logic [zbsf_pkg::PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### hw/rtl/zbuffer_span_fill_unit.sv
`default_nettype none
`include "zbuffer_span_fill_unit_defines.svh"
// Scanline z-buffer span fill. The frame store is one memory of
// MAX_ROWS x MAX_COLUMNS pixels (24-bit depth, 36-bit color) with a
// registered read. A clear writes one pixel per cycle. A span with distinct
// end points first runs four serial divisions (depth, red, green, blue) on
// one shared divider, then walks one pixel per cycle (read, depth test and
// write back overlap across neighboring pixels) and finishes through a drain
// state after its last pixel; a one-pixel span skips the divisions. A read
// passes through a read and a read-wait state. Every item yields one result,
// held in an output register so the next item can be taken while it waits.
module zbuffer_span_fill_unit #(
  parameter int MAX_COLUMNS        = 1024,
  parameter int MAX_ROWS           = 1024,
  parameter int STEP_FRACTION_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire zbsf_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output zbsf_pkg::out_item_t       out_data,
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [5:0]           cfg_paddr,
  input  wire logic [63:0]          cfg_pwdata,
  output logic [63:0]               cfg_prdata,
  output logic                      cfg_pready
);

  localparam int CELLS  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int F      = STEP_FRACTION_BITS;
  localparam int NUM_W  = zbsf_pkg::DEPTH_W + F;
  localparam int STEP_W = NUM_W + 1;
  localparam int ACC_W  = NUM_W + 2;
  localparam int DW     = zbsf_pkg::DIM_W;
  localparam int XW     = zbsf_pkg::X_W;

  // configuration registers
  logic [zbsf_pkg::CFG_W-1:0]   scr_w_r, scr_h_r, fr_l_r, fr_r_r, fr_b_r, fr_t_r;
  logic [zbsf_pkg::COLOR_W-1:0] bg_r;
  logic [zbsf_pkg::DEPTH_W-1:0] far_r;
  logic                         cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= 11'd1024;
      scr_h_r <= 11'd1024;
      fr_l_r  <= 11'd0;
      fr_r_r  <= 11'd1024;
      fr_b_r  <= 11'd0;
      fr_t_r  <= 11'd1024;
      bg_r    <= '0;
      far_r   <= 24'hFFFFFF;
    end else if (cfg_wr) begin
      case (cfg_paddr[5:3])
        zbsf_pkg::REG_SCREEN_WIDTH:  scr_w_r <= cfg_pwdata[10:0];
        zbsf_pkg::REG_SCREEN_HEIGHT: scr_h_r <= cfg_pwdata[10:0];
        zbsf_pkg::REG_FRAME_LEFT:    fr_l_r  <= cfg_pwdata[10:0];
        zbsf_pkg::REG_FRAME_RIGHT:   fr_r_r  <= cfg_pwdata[10:0];
        zbsf_pkg::REG_FRAME_BOTTOM:  fr_b_r  <= cfg_pwdata[10:0];
        zbsf_pkg::REG_FRAME_TOP:     fr_t_r  <= cfg_pwdata[10:0];
        zbsf_pkg::REG_BACKGROUND:    bg_r    <= cfg_pwdata[35:0];
        zbsf_pkg::REG_FAR_DEPTH:     far_r   <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[5:3])
      zbsf_pkg::REG_SCREEN_WIDTH:  cfg_prdata = 64'(scr_w_r);
      zbsf_pkg::REG_SCREEN_HEIGHT: cfg_prdata = 64'(scr_h_r);
      zbsf_pkg::REG_FRAME_LEFT:    cfg_prdata = 64'(fr_l_r);
      zbsf_pkg::REG_FRAME_RIGHT:   cfg_prdata = 64'(fr_r_r);
      zbsf_pkg::REG_FRAME_BOTTOM:  cfg_prdata = 64'(fr_b_r);
      zbsf_pkg::REG_FRAME_TOP:     cfg_prdata = 64'(fr_t_r);
      zbsf_pkg::REG_BACKGROUND:    cfg_prdata = 64'(bg_r);
      zbsf_pkg::REG_FAR_DEPTH:     cfg_prdata = 64'(far_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  // effective screen size
  logic [DW-1:0] eff_w, eff_h;
  assign eff_w = (DW'(scr_w_r) > DW'(MAX_COLUMNS)) ? DW'(MAX_COLUMNS) : DW'(scr_w_r);
  assign eff_h = (DW'(scr_h_r) > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : DW'(scr_h_r);

  // control
  zbsf_pkg::state_t state_r, state_nxt;
  logic accept;
  logic span_bad, read_bad, scr_empty, out_free;

  assign in_ready  = (state_r == zbsf_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign span_bad  = (in_data.left_x > in_data.right_x) || (DW'(in_data.row) >= eff_h);
  assign read_bad  = (DW'(in_data.row) >= eff_h) || (DW'(in_data.left_x) >= eff_w);
  assign scr_empty = (eff_w == '0) || (eff_h == '0);
  assign out_free  = !out_valid || out_ready;

  // datapath registers
  logic [DW-1:0]                cc_r, cr_r;
  logic [ADDR_W-1:0]            base_r;
  logic [XW-1:0]                x_r, rx_r, dx_r;
  logic [1:0]                   ch_r;
  logic [zbsf_pkg::DEPTH_W-1:0] lv_r [4];
  logic [zbsf_pkg::DEPTH_W-1:0] rv_r [4];
  logic signed [STEP_W-1:0]     step_r [4];
  logic signed [ACC_W-1:0]      acc_r [4];
  logic                         p1_vld_r;
  logic [ADDR_W-1:0]            p1_addr_r;
  logic [zbsf_pkg::PIX_W-1:0]   p1_pix_r;
  logic [zbsf_pkg::PIX_W-1:0]   res_pix_r;
  logic [zbsf_pkg::CFG_W-1:0]   res_cnt_r;
  logic                         res_err_r;
  zbsf_pkg::out_item_t          out_r;
  logic                         out_valid_r;

  // memory and divider hookup
  logic                       mem_we, mem_re;
  logic [ADDR_W-1:0]          mem_waddr, mem_raddr;
  logic [zbsf_pkg::PIX_W-1:0] mem_wdata, mem_rdata;
  logic                       div_start, div_done;
  logic [NUM_W-1:0]           div_num, div_quo;
  logic                       clr_inside, x_on, depth_pass;

  zbsf_mem #(.DEPTH(CELLS), .ADDR_W(ADDR_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // magnitude of the end point difference for the current channel
  logic signed [zbsf_pkg::DEPTH_W:0] diff;
  logic                              diff_neg;
  logic [zbsf_pkg::DEPTH_W-1:0]      diff_mag;
  assign diff     = $signed({1'b0, rv_r[ch_r]}) - $signed({1'b0, lv_r[ch_r]});
  assign diff_neg = diff[zbsf_pkg::DEPTH_W];
  assign diff_mag = diff_neg ? zbsf_pkg::DEPTH_W'(-diff) : zbsf_pkg::DEPTH_W'(diff);
  assign div_num  = {diff_mag, {F{1'b0}}};

  zbsf_div #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (dx_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  function automatic logic [zbsf_pkg::DEPTH_W-1:0] take(input logic signed [ACC_W-1:0] a,
                                                       input logic [zbsf_pkg::DEPTH_W-1:0] lim);
    logic [ACC_W-1:0] v;
    v = ACC_W'(a >>> F);
    if (a < 0) return '0;
    if (v > ACC_W'(lim)) return lim;
    return v[zbsf_pkg::DEPTH_W-1:0];
  endfunction

  logic [zbsf_pkg::DEPTH_W-1:0] tk_d, tk_r, tk_g, tk_b;
  assign tk_d = take(acc_r[0], 24'hFFFFFF);
  assign tk_r = take(acc_r[1], 24'h000FFF);
  assign tk_g = take(acc_r[2], 24'h000FFF);
  assign tk_b = take(acc_r[3], 24'h000FFF);

  assign clr_inside = (cc_r >= DW'(fr_l_r)) && (cc_r < DW'(fr_r_r)) &&
                      (cr_r >= DW'(fr_b_r)) && (cr_r < DW'(fr_t_r));
  assign x_on       = DW'(x_r) < eff_w;
  assign depth_pass = p1_pix_r[59:36] < mem_rdata[59:36];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      zbsf_pkg::S_IDLE: begin
        if (accept) begin
          case (in_data.kind)
            zbsf_pkg::KIND_CLEAR: state_nxt = scr_empty ? zbsf_pkg::S_DONE : zbsf_pkg::S_CLEAR;
            zbsf_pkg::KIND_SPAN: begin
              if (span_bad) state_nxt = zbsf_pkg::S_DONE;
              else if (in_data.left_x == in_data.right_x) state_nxt = zbsf_pkg::S_WALK;
              else state_nxt = zbsf_pkg::S_DIV;
            end
            zbsf_pkg::KIND_READ: state_nxt = read_bad ? zbsf_pkg::S_DONE : zbsf_pkg::S_READ;
            default: state_nxt = zbsf_pkg::S_DONE;
          endcase
        end
      end
      zbsf_pkg::S_CLEAR: begin
        if (cc_r == eff_w - 1'b1 && cr_r == eff_h - 1'b1) state_nxt = zbsf_pkg::S_DONE;
      end
      zbsf_pkg::S_DIV:  state_nxt = zbsf_pkg::S_DIVW;
      zbsf_pkg::S_DIVW: begin
        if (div_done) state_nxt = (ch_r == 2'd3) ? zbsf_pkg::S_WALK : zbsf_pkg::S_DIV;
      end
      zbsf_pkg::S_WALK:  if (x_r == rx_r) state_nxt = zbsf_pkg::S_DRAIN;
      zbsf_pkg::S_DRAIN: state_nxt = zbsf_pkg::S_DONE;
      zbsf_pkg::S_READ:  state_nxt = zbsf_pkg::S_READW;
      zbsf_pkg::S_READW: state_nxt = zbsf_pkg::S_DONE;
      zbsf_pkg::S_DONE:  if (out_free) state_nxt = zbsf_pkg::S_IDLE;
      default: state_nxt = zbsf_pkg::S_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = p1_addr_r;
    mem_wdata = p1_pix_r;
    mem_re    = 1'b0;
    mem_raddr = base_r + ADDR_W'(x_r);
    div_start = 1'b0;
    case (state_r)
      zbsf_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = base_r + ADDR_W'(cc_r);
        mem_wdata = {far_r, clr_inside ? bg_r : {zbsf_pkg::COLOR_W{1'b0}}};
      end
      zbsf_pkg::S_DIV: div_start = 1'b1;
      zbsf_pkg::S_WALK: begin
        mem_re = x_on;
        mem_we = p1_vld_r && depth_pass;
      end
      zbsf_pkg::S_DRAIN: mem_we = p1_vld_r && depth_pass;
      zbsf_pkg::S_READ:  mem_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zbsf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      p1_vld_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      p1_vld_r <= (state_r == zbsf_pkg::S_WALK) && x_on;
      if (state_r == zbsf_pkg::S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      zbsf_pkg::S_IDLE: begin
        if (accept) begin
          res_pix_r <= '0;
          res_cnt_r <= '0;
          res_err_r <= ((in_data.kind == zbsf_pkg::KIND_SPAN) && span_bad) ||
                       ((in_data.kind == zbsf_pkg::KIND_READ) && read_bad);
          base_r    <= (in_data.kind == zbsf_pkg::KIND_CLEAR) ? '0 :
                       ADDR_W'(ADDR_W'(in_data.row) * ADDR_W'(MAX_COLUMNS));
          cc_r      <= '0;
          cr_r      <= '0;
          x_r       <= in_data.left_x;
          rx_r      <= in_data.right_x;
          dx_r      <= in_data.right_x - in_data.left_x;
          ch_r      <= 2'd0;
          lv_r[0]   <= in_data.left_depth;
          lv_r[1]   <= 24'(in_data.left_red);
          lv_r[2]   <= 24'(in_data.left_green);
          lv_r[3]   <= 24'(in_data.left_blue);
          rv_r[0]   <= in_data.right_depth;
          rv_r[1]   <= 24'(in_data.right_red);
          rv_r[2]   <= 24'(in_data.right_green);
          rv_r[3]   <= 24'(in_data.right_blue);
          acc_r[0]  <= ACC_W'({in_data.left_depth, {F{1'b0}}});
          acc_r[1]  <= ACC_W'({in_data.left_red, {F{1'b0}}});
          acc_r[2]  <= ACC_W'({in_data.left_green, {F{1'b0}}});
          acc_r[3]  <= ACC_W'({in_data.left_blue, {F{1'b0}}});
          for (int i = 0; i < 4; i++) step_r[i] <= '0;
        end
      end
      zbsf_pkg::S_CLEAR: begin
        if (cc_r == eff_w - 1'b1) begin
          cc_r   <= '0;
          cr_r   <= cr_r + 1'b1;
          base_r <= base_r + ADDR_W'(MAX_COLUMNS);
        end else begin
          cc_r <= cc_r + 1'b1;
        end
      end
      zbsf_pkg::S_DIVW: begin
        if (div_done) begin
          step_r[ch_r] <= diff_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
          ch_r         <= ch_r + 1'b1;
        end
      end
      zbsf_pkg::S_WALK: begin
        // issue this pixel, finish the one read last cycle
        p1_addr_r <= base_r + ADDR_W'(x_r);
        p1_pix_r  <= {tk_d, tk_r[11:0], tk_g[11:0], tk_b[11:0]};
        if (!x_on) res_err_r <= 1'b1;
        if (p1_vld_r && depth_pass) res_cnt_r <= res_cnt_r + 1'b1;
        for (int i = 0; i < 4; i++) acc_r[i] <= acc_r[i] + ACC_W'(step_r[i]);
        x_r <= x_r + 1'b1;
      end
      zbsf_pkg::S_DRAIN: begin
        if (p1_vld_r && depth_pass) res_cnt_r <= res_cnt_r + 1'b1;
      end
      zbsf_pkg::S_READW: res_pix_r <= mem_rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == zbsf_pkg::S_DONE && out_free) begin
      out_r.pixel_depth    <= res_pix_r[59:36];
      out_r.pixel_red      <= res_pix_r[35:24];
      out_r.pixel_green    <= res_pix_r[23:12];
      out_r.pixel_blue     <= res_pix_r[11:0];
      out_r.pixels_written <= res_cnt_r;
      out_r.range_error    <= res_err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic wr_state, done_go, idle_loaded;
  assign wr_state    = (state_r == zbsf_pkg::S_CLEAR) || (state_r == zbsf_pkg::S_WALK) ||
                       (state_r == zbsf_pkg::S_DRAIN);
  assign done_go     = (state_r == zbsf_pkg::S_DONE) && out_free;
  assign idle_loaded = out_valid && (state_r == zbsf_pkg::S_IDLE);

  `ZBSF_ASSERT_IMP(a_we_states, mem_we, wr_state)
  `ZBSF_ASSERT_IMP(a_div_wait, div_done, state_r == zbsf_pkg::S_DIVW)
  `ZBSF_ASSERT_NXT(a_result_loaded, done_go, idle_loaded)

endmodule
`default_nettype wire
